@@ hdl/drfl_pkg.sv @@
package drfl_pkg;

	localparam int POOL_ENTRIES = 64;
	localparam int IDX_W = $clog2(POOL_ENTRIES);
	localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
	localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_ENTRIES);

	localparam int FUNC_W = 2;
	localparam int ENTRY_W = 6;
	localparam int POOL_COUNT_W = 7;
	localparam logic [POOL_COUNT_W-1:0] POOL_COUNT_RESET = POOL_COUNT_W'(64);

	localparam logic REG_POOL_COUNT = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FN_INIT    = 2'd0,
		FN_ALLOC   = 2'd1,
		FN_RELEASE = 2'd2,
		FN_TICK    = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [ENTRY_W-1:0] entry_index;
	} req_t;

	typedef struct packed {
		logic               granted;
		logic [ENTRY_W-1:0] entry;
		logic               bad_release;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic walk;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
		logic count_zero;
	} stat_t;

endpackage

@@ hdl/drfl_ram.sv @@
module drfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/drfl_datapath.sv @@
module drfl_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  drfl_pkg::cmd_t                     cmd,
	input  drfl_pkg::req_t                     req,
	input  logic [drfl_pkg::POOL_COUNT_W-1:0]  pool_count,
	output drfl_pkg::stat_t                    stat,
	output drfl_pkg::rsp_t                     rsp
);
	import drfl_pkg::*;

	func_t              func_q;
	logic [ENTRY_W-1:0] idx_q;
	logic [LINK_W-1:0]  free_head_q;
	logic [LINK_W-1:0]  pend_head_q;
	logic [LINK_W-1:0]  pend_tail_q;
	logic [LINK_W-1:0]  quar_head_q;
	logic [LINK_W-1:0]  quar_tail_q;
	logic [LINK_W-1:0]  cnt_q;
	rsp_t               rsp_q;

	logic [LINK_W-1:0]  eff_count;
	logic [LINK_W-1:0]  cnt_inc;
	logic               walk_last;
	logic               bad;
	logic               fh_nil;
	logic               ph_nil;
	logic               pt_nil;
	logic               qh_nil;
	logic               qt_nil;
	logic               we;
	logic [IDX_W-1:0]   waddr;
	logic [LINK_W-1:0]  wdata;
	logic [IDX_W-1:0]   raddr;
	logic [LINK_W-1:0]  rdata;
	logic [LINK_W-1:0]  rd_norm;
	rsp_t               rsp_d;

	assign eff_count = (32'(pool_count) > 32'(POOL_ENTRIES)) ? NIL : LINK_W'(pool_count);
	assign cnt_inc   = cnt_q + 1'b1;
	assign walk_last = (cnt_inc == eff_count);
	assign bad       = (32'(idx_q) >= 32'(eff_count));
	assign fh_nil    = (free_head_q == NIL);
	assign ph_nil    = (pend_head_q == NIL);
	assign pt_nil    = (pend_tail_q == NIL);
	assign qh_nil    = (quar_head_q == NIL);
	assign qt_nil    = (quar_tail_q == NIL);
	assign rd_norm   = (rdata < NIL) ? rdata : NIL;
	assign raddr     = fh_nil ? '0 : free_head_q[IDX_W-1:0];

	assign stat.walk_last  = walk_last;
	assign stat.count_zero = (eff_count == '0);
	assign rsp             = rsp_q;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[IDX_W-1:0];
		wdata = walk_last ? NIL : cnt_inc;
		if (cmd.walk) begin
			we = 1'b1;
		end else if (cmd.commit) begin
			unique case (func_q)
				FN_RELEASE: begin
					we    = !bad;
					waddr = IDX_W'(idx_q);
					wdata = pend_head_q;
				end
				FN_TICK: begin
					we    = !qh_nil && !qt_nil;
					waddr = quar_tail_q[IDX_W-1:0];
					wdata = free_head_q;
				end
				FN_INIT, FN_ALLOC: begin
				end
			endcase
		end
	end

	always_comb begin
		rsp_d = '0;
		unique case (func_q)
			FN_ALLOC: begin
				if (!fh_nil) begin
					rsp_d.granted = 1'b1;
					rsp_d.entry   = ENTRY_W'(free_head_q);
				end
			end
			FN_RELEASE: rsp_d.bad_release = bad;
			FN_INIT, FN_TICK: begin
			end
		endcase
	end

	drfl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(POOL_ENTRIES)
	) u_link_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			idx_q  <= req.entry_index;
			cnt_q  <= '0;
		end else if (cmd.walk) begin
			cnt_q <= cnt_inc;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= NIL;
			pend_head_q <= NIL;
			pend_tail_q <= NIL;
			quar_head_q <= NIL;
			quar_tail_q <= NIL;
		end else if (cmd.commit) begin
			unique case (func_q)
				FN_INIT: begin
					free_head_q <= stat.count_zero ? NIL : '0;
					pend_head_q <= NIL;
					pend_tail_q <= NIL;
					quar_head_q <= NIL;
					quar_tail_q <= NIL;
				end
				FN_ALLOC: begin
					if (!fh_nil) begin
						free_head_q <= rd_norm;
					end
				end
				FN_RELEASE: begin
					if (!bad) begin
						pend_head_q <= LINK_W'(idx_q);
						if (pt_nil) begin
							pend_tail_q <= LINK_W'(idx_q);
						end
					end
				end
				FN_TICK: begin
					if (!qh_nil) begin
						free_head_q <= quar_head_q;
					end
					if (!ph_nil) begin
						quar_head_q <= pend_head_q;
						quar_tail_q <= pend_tail_q;
						pend_head_q <= NIL;
						pend_tail_q <= NIL;
					end else if (!qh_nil) begin
						quar_head_q <= NIL;
						quar_tail_q <= NIL;
					end
				end
			endcase
		end
	end

	a_free_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= NIL)
		else $error("free head out of range");

	a_pend_pair: assert property (@(posedge clk) disable iff (!arst_n)
		ph_nil == pt_nil)
		else $error("pending head and tail disagree on empty");

	a_quar_pair: assert property (@(posedge clk) disable iff (!arst_n)
		qh_nil == qt_nil)
		else $error("quarantine head and tail disagree on empty");

endmodule

@@ hdl/drfl_ctrl.sv @@
module drfl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  drfl_pkg::func_t  req_func,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  drfl_pkg::stat_t  stat,
	output drfl_pkg::cmd_t   cmd
);
	import drfl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign req_ready  = in_ready_q;
	assign rsp_valid  = out_valid_q;
	assign cmd.load   = req_valid && in_ready_q;
	assign cmd.walk   = (state_q == ST_WALK);
	assign cmd.commit = (state_q == ST_EXEC) && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						in_ready_q <= 1'b0;
						if (req_func == FN_INIT && !stat.count_zero) begin
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_WALK: begin
					if (stat.walk_last) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.commit) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("transfer accepted while an item is in flight");

	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd.commit))
		else $error("result raised without a commit");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (state_q == ST_IDLE))
		else $error("ready outside idle");

endmodule

@@ hdl/deferred_release_free_list.sv @@
// Free-list pool manager with deferred release.
// Requests (req_valid/req_ready, req) carry a function code and an entry
// index: initialize, allocate, release, frame tick. Every request gives one
// result on rsp_valid/rsp_ready (granted, entry, bad_release).
// Allocate, release and tick: the transfer registers the request; the
// update step then uses the registered read of the link RAM at the free
// head and updates the list heads. Initialize first walks the entries,
// one link RAM write per chained entry. One request is in flight at a
// time: a new request is not taken before the last one is updated.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the following result holds in
// the update step and req_ready stays low until the register drains.
// Reset empties all lists; the link RAM holds nothing until initialize.
// pool_count (APB port, byte address 0) must be written only while idle,
// which the block does not enforce; values above the pool size act as 64.
module deferred_release_free_list (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  drfl_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output drfl_pkg::rsp_t  rsp,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import drfl_pkg::*;

	logic [POOL_COUNT_W-1:0] pool_count_q;
	cmd_t                    cmd;
	stat_t                   stat;
	logic                    reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_POOL_COUNT);
	assign prdata  = reg_hit ? 32'(pool_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_count_q <= POOL_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			pool_count_q <= pwdata[POOL_COUNT_W-1:0];
		end
	end

	drfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_func (req.func),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	drfl_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.pool_count(pool_count_q),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

@@ tb/sv/deferred_release_free_list_test.sv @@
module deferred_release_free_list_test;
	import drfl_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 175;

	class pool_scoreboard;
		logic [LINK_W-1:0] link [POOL_ENTRIES];
		logic [LINK_W-1:0] free_head = NIL;
		logic [LINK_W-1:0] pend_head = NIL;
		logic [LINK_W-1:0] pend_tail = NIL;
		logic [LINK_W-1:0] quar_head = NIL;
		logic [LINK_W-1:0] quar_tail = NIL;
		logic [POOL_COUNT_W-1:0] pool_count = POOL_COUNT_RESET;
		rsp_t want_q[$];
		int mismatches = 0;

		function logic [LINK_W-1:0] clip(logic [LINK_W-1:0] v);
			return (v < NIL) ? v : NIL;
		endfunction

		function int live_count();
			return (pool_count > POOL_ENTRIES) ? POOL_ENTRIES : int'(pool_count);
		endfunction

		function int outstanding();
			return want_q.size();
		endfunction

		function rsp_t note(req_t r);
			rsp_t e;
			logic [LINK_W-1:0] h;
			logic [LINK_W-1:0] t;
			int n;
			e = '0;
			n = live_count();
			case (r.func)
				FN_INIT: begin
					if (n == 0) begin
						free_head = NIL;
					end else begin
						for (int i = 0; i + 1 < n; i++)
							link[i] = LINK_W'(i + 1);
						link[n - 1] = NIL;
						free_head = '0;
					end
					pend_head = NIL;
					pend_tail = NIL;
					quar_head = NIL;
					quar_tail = NIL;
				end
				FN_ALLOC: begin
					h = clip(free_head);
					if (h != NIL) begin
						e.granted = 1'b1;
						e.entry = h[ENTRY_W-1:0];
						free_head = clip(link[h[ENTRY_W-1:0]]);
					end
				end
				FN_RELEASE: begin
					if (int'(r.entry_index) >= n) begin
						e.bad_release = 1'b1;
					end else begin
						if (clip(pend_tail) == NIL)
							pend_tail = LINK_W'(r.entry_index);
						link[r.entry_index] = clip(pend_head);
						pend_head = LINK_W'(r.entry_index);
					end
				end
				default: begin
					if (clip(quar_head) != NIL) begin
						t = clip(quar_tail);
						if (t != NIL)
							link[t[ENTRY_W-1:0]] = clip(free_head);
						free_head = clip(quar_head);
						quar_head = NIL;
						quar_tail = NIL;
					end
					if (clip(pend_head) != NIL) begin
						quar_head = clip(pend_head);
						quar_tail = clip(pend_tail);
						pend_head = NIL;
						pend_tail = NIL;
					end
				end
			endcase
			want_q.push_back(e);
			return e;
		endfunction

		function void check(rsp_t got);
			rsp_t e;
			if (want_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: granted=%0d entry=%0d bad_release=%0d",
						got.granted, got.entry, got.bad_release);
				return;
			end
			e = want_q.pop_front();
			if (got.granted !== e.granted || got.entry !== e.entry ||
					got.bad_release !== e.bad_release) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: got granted=%0d entry=%0d bad_release=%0d, want granted=%0d entry=%0d bad_release=%0d",
						got.granted, got.entry, got.bad_release,
						e.granted, e.entry, e.bad_release);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	pool_scoreboard sb;
	logic [ENTRY_W-1:0] held[$];
	int stall_pct = 20;
	int rsp_hold = 0;
	int quiet = 0;

	deferred_release_free_list dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			sb.check(rsp);
		if (stall_pct == 0) begin
			rsp_ready <= 1'b1;
		end else if (rsp_hold != 0) begin
			rsp_hold--;
			rsp_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct / 3) begin
			rsp_hold = $urandom_range(0, 6);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic issue(func_t f, logic [ENTRY_W-1:0] idx);
		req_t r;
		rsp_t e;
		r.func = f;
		r.entry_index = idx;
		if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && req_ready));
		e = sb.note(r);
		if (f == FN_INIT)
			held.delete();
		if (e.granted)
			held.push_back(e.entry);
	endtask

	task automatic set_pool_count(logic [POOL_COUNT_W-1:0] cnt);
		logic [31:0] v;
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		v = ($urandom() & ~32'h7f) | 32'(cnt);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * REG_POOL_COUNT);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.pool_count = v[POOL_COUNT_W-1:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_item();
		int roll;
		int k;
		logic [ENTRY_W-1:0] idx;
		roll = $urandom_range(0, 99);
		idx = ENTRY_W'($urandom());
		if (roll < 2) begin
			issue(FN_INIT, idx);
		end else if (roll < 42) begin
			issue(FN_ALLOC, idx);
		end else if (roll < 77) begin
			if (held.size() != 0 && $urandom_range(0, 4) != 0) begin
				k = $urandom_range(0, held.size() - 1);
				idx = held[k];
				held.delete(k);
			end
			issue(FN_RELEASE, idx);
		end else begin
			issue(FN_TICK, idx);
		end
	endtask

	initial begin
		logic [POOL_COUNT_W-1:0] counts [8];
		sb = new;
		counts = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd65, 7'd63, 7'd0, 7'd64};
		counts[6] = POOL_COUNT_W'($urandom_range(0, 127));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(FN_ALLOC, 6'd0);
		issue(FN_RELEASE, 6'd63);
		issue(FN_RELEASE, 6'd0);
		issue(FN_TICK, 6'd0);
		issue(FN_ALLOC, 6'd0);
		issue(FN_TICK, 6'd63);
		issue(FN_ALLOC, 6'd63);
		issue(FN_ALLOC, 6'd0);
		issue(FN_ALLOC, 6'd0);

		set_pool_count(7'd2);
		issue(FN_INIT, 6'd63);
		issue(FN_RELEASE, 6'd2);
		issue(FN_ALLOC, 6'd0);
		issue(FN_ALLOC, 6'd0);
		issue(FN_ALLOC, 6'd0);
		issue(FN_RELEASE, 6'd1);
		issue(FN_RELEASE, 6'd1);
		issue(FN_TICK, 6'd0);
		issue(FN_TICK, 6'd0);
		issue(FN_ALLOC, 6'd0);
		issue(FN_ALLOC, 6'd0);

		set_pool_count(7'd127);
		issue(FN_INIT, 6'd0);
		issue(FN_RELEASE, 6'd63);
		issue(FN_ALLOC, 6'd0);

		set_pool_count(7'd0);
		issue(FN_INIT, 6'd0);
		issue(FN_ALLOC, 6'd0);
		issue(FN_RELEASE, 6'd0);

		for (int p = 0; p < 8; p++) begin
			set_pool_count(counts[p]);
			case (p % 3)
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 40;
			endcase
			if (p == 7)
				stall_pct = 0;
			issue(FN_INIT, ENTRY_W'($urandom()));
			repeat (PHASE_ITEMS) random_item();
		end

		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
